[hw/rtl/adnp_pkg.sv]
// adnp_pkg: shared types, character codes and scaling table of the ascii decimal number parser
// no dependencies; used by adnp_scan, adnp_scaler and ascii_decimal_number_parser_core
`timescale 1ns / 1ps

package adnp_pkg;

	// result word width at the port, and default width of the internal magnitude
	localparam int unsigned OUT_BITS       = 64;
	localparam int unsigned DEF_VALUE_BITS = 64;

	// configuration port
	localparam int unsigned CFG_DATA_BITS  = 5;
	localparam int unsigned FRAC_BITS      = 5;
	localparam logic [FRAC_BITS-1:0] FRAC_COUNT_MAX = '1;

	typedef enum logic {
		REG_PARSE_MODE  = 1'b0,
		REG_FRAC_DIGITS = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		MODE_UINT  = 3'd0,
		MODE_SINT  = 3'd1,
		MODE_DIGIT = 3'd2,
		MODE_UFIX  = 3'd3,
		MODE_SFIX  = 3'd4
	} mode_t;

	localparam mode_t MODE_RESET = MODE_SINT;

	typedef enum logic [1:0] {
		PH_SKIP = 2'd0,
		PH_INT  = 2'd1,
		PH_FRAC = 2'd2
	} phase_t;

	// character codes
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = CHAR_ZERO + 8'd9;
	localparam logic [3:0] RADIX      = 4'd10;

	// control that travels with a finished token through the scaling pipe
	typedef struct packed {
		logic                 negate;
		logic                 ovf;
		logic [FRAC_BITS-1:0] scale;
	} tok_ctl_t;

	// scaling pipe: each stage multiplies by a small power of ten when its
	// bit of the scale count is set; bit 3 takes two stages, bit 4 four
	localparam int unsigned NUM_SCALE_STAGES = 9;
	localparam int unsigned MULT_BITS        = 14;
	localparam int unsigned SCALE_SEL_BITS   = $clog2(FRAC_BITS);

	function automatic logic [SCALE_SEL_BITS-1:0] stage_bit(input int unsigned idx);
		logic [SCALE_SEL_BITS-1:0] b;
		case (idx)
			0:       b = SCALE_SEL_BITS'(0);
			1:       b = SCALE_SEL_BITS'(1);
			2:       b = SCALE_SEL_BITS'(2);
			3, 4:    b = SCALE_SEL_BITS'(3);
			default: b = SCALE_SEL_BITS'(4);
		endcase
		return b;
	endfunction

	function automatic logic [MULT_BITS-1:0] stage_mult(input int unsigned idx);
		logic [MULT_BITS-1:0] m;
		case (idx)
			0:       m = MULT_BITS'(10);
			1:       m = MULT_BITS'(100);
			default: m = MULT_BITS'(10000);
		endcase
		return m;
	endfunction

endpackage

[hw/rtl/adnp_scan.sv]
// adnp_scan: per-byte token scanner, holds the token state and accumulates digits
// depends on adnp_pkg; feeds adnp_scaler with one request per finished token
`timescale 1ns / 1ps

module adnp_scan #(
	parameter int unsigned VALUE_BITS = adnp_pkg::DEF_VALUE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [7:0]                       in_byte,
	input  adnp_pkg::mode_t                  mode,
	input  logic [adnp_pkg::FRAC_BITS-1:0]   frac_digits,
	output logic                             req_valid,
	output logic [VALUE_BITS-1:0]            req_value,
	output adnp_pkg::tok_ctl_t               req_ctl
);

	adnp_pkg::phase_t                   phase_q, phase_d;
	logic                               neg_q, neg_d;
	logic [VALUE_BITS-1:0]              acc_q, acc_d;
	logic [adnp_pkg::FRAC_BITS-1:0]     fcnt_q, fcnt_d;
	logic                               ovf_q, ovf_d;

	logic                               is_digit;
	logic [3:0]                         digit_val;
	logic                               is_signed;
	logic                               is_fixed;
	logic [VALUE_BITS+3:0]              push_wide;
	logic                               push_ovf;

	assign is_digit  = (in_byte >= adnp_pkg::CHAR_ZERO) && (in_byte <= adnp_pkg::CHAR_NINE);
	assign digit_val = is_digit ? 4'(in_byte - adnp_pkg::CHAR_ZERO) : 4'd0;
	assign is_signed = (mode == adnp_pkg::MODE_SINT) || (mode == adnp_pkg::MODE_SFIX);
	assign is_fixed  = (mode == adnp_pkg::MODE_UFIX) || (mode == adnp_pkg::MODE_SFIX);

	// acc * 10 + digit, with the bits above the magnitude showing a wrap
	assign push_wide = (VALUE_BITS+4)'(acc_q) * (VALUE_BITS+4)'(adnp_pkg::RADIX)
		+ (VALUE_BITS+4)'(digit_val);
	assign push_ovf  = |push_wide[VALUE_BITS+3:VALUE_BITS];

	always_comb begin
		phase_d   = phase_q;
		neg_d     = neg_q;
		acc_d     = acc_q;
		fcnt_d    = fcnt_q;
		ovf_d     = ovf_q;
		req_valid = 1'b0;
		req_value = acc_q;
		req_ctl   = '0;
		if (accept) begin
			if (mode == adnp_pkg::MODE_DIGIT) begin
				// every digit stands alone, any partial token is dropped
				phase_d   = adnp_pkg::PH_SKIP;
				neg_d     = 1'b0;
				acc_d     = '0;
				fcnt_d    = '0;
				ovf_d     = 1'b0;
				req_valid = is_digit;
				req_value = VALUE_BITS'(digit_val);
			end else begin
				unique case (phase_q)
					adnp_pkg::PH_INT, adnp_pkg::PH_FRAC: begin
						if (is_digit) begin
							acc_d = push_wide[VALUE_BITS-1:0];
							ovf_d = ovf_q | push_ovf;
							if (phase_q == adnp_pkg::PH_FRAC && fcnt_q != adnp_pkg::FRAC_COUNT_MAX)
								fcnt_d = fcnt_q + 1'b1;
						end else if (phase_q == adnp_pkg::PH_INT && in_byte == adnp_pkg::CHAR_DOT
								&& is_fixed) begin
							phase_d = adnp_pkg::PH_FRAC;
						end else begin
							// terminator: hand the token on and start afresh
							req_valid      = 1'b1;
							req_value      = acc_q;
							req_ctl.ovf    = ovf_q;
							req_ctl.negate = is_signed && neg_q;
							req_ctl.scale  = (is_fixed && frac_digits > fcnt_q)
								? frac_digits - fcnt_q : '0;
							phase_d = adnp_pkg::PH_SKIP;
							neg_d   = 1'b0;
							acc_d   = '0;
							fcnt_d  = '0;
							ovf_d   = 1'b0;
						end
					end
					default: begin
						if (is_digit) begin
							phase_d = adnp_pkg::PH_INT;
							acc_d   = VALUE_BITS'(digit_val);
							fcnt_d  = '0;
							ovf_d   = 1'b0;
						end else if (in_byte == adnp_pkg::CHAR_MINUS && is_signed) begin
							neg_d = 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= adnp_pkg::PH_SKIP;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			fcnt_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			acc_q   <= acc_d;
			fcnt_q  <= fcnt_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

[hw/rtl/adnp_scaler.sv]
// adnp_scaler: power-of-ten scaling pipe, sign handling and the result register
// depends on adnp_pkg; takes finished tokens from adnp_scan
`timescale 1ns / 1ps

module adnp_scaler #(
	parameter int unsigned VALUE_BITS = adnp_pkg::DEF_VALUE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic [VALUE_BITS-1:0]           req_value,
	input  adnp_pkg::tok_ctl_t              req_ctl,
	output logic                            req_ready,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [adnp_pkg::OUT_BITS-1:0]   number_value,
	output logic                            overflow_flag
);

	localparam int unsigned N = adnp_pkg::NUM_SCALE_STAGES;
	localparam int unsigned PW = VALUE_BITS + adnp_pkg::MULT_BITS;

	logic [N:1]                 vld_s;
	logic [VALUE_BITS-1:0]      val_s [1:N];
	adnp_pkg::tok_ctl_t         ctl_s [1:N];
	logic [N+1:1]               rdy;

	logic                       out_valid_q;
	logic [adnp_pkg::OUT_BITS-1:0] out_value_q;
	logic                       out_ovf_q;
	logic [VALUE_BITS-1:0]      final_val;

	// a stage moves on when it is empty or the one after it moves
	always_comb begin
		rdy[N+1] = !out_valid_q || !out_stall;
		for (int j = N; j >= 1; j--)
			rdy[j] = !vld_s[j] || rdy[j+1];
	end

	assign req_ready = rdy[1];

	for (genvar g = 0; g < N; g++) begin : g_stage
		localparam logic [adnp_pkg::SCALE_SEL_BITS-1:0] SEL = adnp_pkg::stage_bit(g);
		localparam logic [adnp_pkg::MULT_BITS-1:0] MULT = adnp_pkg::stage_mult(g);

		logic                  prev_vld;
		logic [VALUE_BITS-1:0] prev_val;
		adnp_pkg::tok_ctl_t    prev_ctl;
		logic [PW-1:0]         prod;
		logic [VALUE_BITS-1:0] next_val;
		adnp_pkg::tok_ctl_t    next_ctl;

		if (g == 0) begin : g_first
			assign prev_vld = req_valid;
			assign prev_val = req_value;
			assign prev_ctl = req_ctl;
		end else begin : g_rest
			assign prev_vld = vld_s[g];
			assign prev_val = val_s[g];
			assign prev_ctl = ctl_s[g];
		end

		// bits above the magnitude mean the exact product no longer fits
		assign prod = PW'(prev_val) * PW'(MULT);

		always_comb begin
			next_ctl = prev_ctl;
			next_val = prev_val;
			if (prev_ctl.scale[SEL]) begin
				next_val     = prod[VALUE_BITS-1:0];
				next_ctl.ovf = prev_ctl.ovf | (|prod[PW-1:VALUE_BITS]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[g+1] <= 1'b0;
			else if (rdy[g+1])
				vld_s[g+1] <= prev_vld;
		end

		always_ff @(posedge clk) begin
			if (rdy[g+1]) begin
				val_s[g+1] <= next_val;
				ctl_s[g+1] <= next_ctl;
			end
		end
	end

	assign final_val = ctl_s[N].negate ? ({VALUE_BITS{1'b0}} - val_s[N]) : val_s[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (rdy[N+1])
			out_valid_q <= vld_s[N];
	end

	always_ff @(posedge clk) begin
		if (rdy[N+1]) begin
			out_value_q <= adnp_pkg::OUT_BITS'(signed'(final_val));
			out_ovf_q   <= ctl_s[N].ovf;
		end
	end

	assign out_valid     = out_valid_q;
	assign number_value  = out_value_q;
	assign overflow_flag = out_ovf_q;

endmodule

[hw/rtl/ascii_decimal_number_parser_core.sv]
// ascii_decimal_number_parser_core: top level of the ascii decimal number parser
// depends on adnp_pkg, adnp_scan and adnp_scaler
`timescale 1ns / 1ps

// usage
//  - input channel: in_valid / in_stall carry one ascii character per request
//    in in_byte; the request is taken at a rising edge with in_valid high and
//    in_stall low
//  - output channel: out_valid / out_stall carry one parsed number per request,
//    number_value (two's complement, 64 bits) with overflow_flag
//  - a token's result leaves for the character that ends it (or for each digit
//    in single digit mode); other characters give no result
//  - throughput: one character per clock, every clock, while the output drains
//  - path: the edge that takes the ending character loads the first of nine
//    scaling stages (powers of ten chosen by the missing fraction places); the
//    token moves on through the later stages, as the pipe allows, into the
//    result register that also applies the sign
//  - stall: when out_stall holds a waiting result, the pipe keeps filling its
//    empty stages and in_stall rises only once no stage can move
//  - configuration: cfg_we writes cfg_data into the register chosen by
//    cfg_index (parse_mode, frac_digits) at the next edge; only while idle
//  - reset: arst_n clears the pipe, the token state and sets parse_mode to
//    signed integer and frac_digits to zero
module ascii_decimal_number_parser_core #(
	parameter int unsigned VALUE_BITS = adnp_pkg::DEF_VALUE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// character requests
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           in_byte,
	// number requests
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [adnp_pkg::OUT_BITS-1:0]        number_value,
	output logic                                 overflow_flag,
	// register writes
	input  logic                                 cfg_we,
	input  adnp_pkg::reg_index_t                 cfg_index,
	input  logic [adnp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	adnp_pkg::mode_t                   parse_mode_q;
	logic [adnp_pkg::FRAC_BITS-1:0]    frac_digits_q;

	logic                              accept;
	logic                              req_valid;
	logic                              req_ready;
	logic [VALUE_BITS-1:0]             req_value;
	adnp_pkg::tok_ctl_t                req_ctl;

	// register file: mode codes 5 to 7 fall through to unsigned integer in the scanner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_mode_q  <= adnp_pkg::MODE_RESET;
			frac_digits_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				adnp_pkg::REG_PARSE_MODE:  parse_mode_q  <= adnp_pkg::mode_t'(cfg_data[2:0]);
				adnp_pkg::REG_FRAC_DIGITS: frac_digits_q <= cfg_data[adnp_pkg::FRAC_BITS-1:0];
			endcase
		end
	end

	// a character is taken whenever the first scaling stage can take a token
	assign in_stall = !req_ready;
	assign accept   = in_valid && req_ready;

	adnp_scan #(
		.VALUE_BITS (VALUE_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (in_byte),
		.mode        (parse_mode_q),
		.frac_digits (frac_digits_q),
		.req_valid   (req_valid),
		.req_value   (req_value),
		.req_ctl     (req_ctl)
	);

	adnp_scaler #(
		.VALUE_BITS (VALUE_BITS)
	) u_scaler (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_value     (req_value),
		.req_ctl       (req_ctl),
		.req_ready     (req_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.number_value  (number_value),
		.overflow_flag (overflow_flag)
	);

endmodule

[tb/sv/ascii_decimal_number_parser_core_test.sv]
// ascii_decimal_number_parser_core_test: self-checking bench for the ascii decimal number parser
// depends on adnp_pkg and ascii_decimal_number_parser_core; needs no files or arguments
`timescale 1ns / 1ps

module ascii_decimal_number_parser_core_test;
	import adnp_pkg::*;

	// bench timing and sizing
	localparam int unsigned PHASE_ITEMS   = 125;   // characters per register setting
	localparam int unsigned NUM_PHASES    = 14;
	localparam int unsigned LATENCY_PAD   = 24;    // scaling pipe plus margin
	localparam int unsigned HOLD_CYCLES   = 160;   // long receiver hold-off
	// slowest quiet stretch: long hold, sender gap, pipe latency, pad and register writes;
	// taken several times over
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned FRAC_TOP      = 18;    // widest fraction setting in use

	// parse modes with no name of their own; they behave as unsigned integer
	localparam logic [2:0] MODE_SPARE_A = 3'd5;
	localparam logic [2:0] MODE_SPARE_B = 3'd6;
	localparam logic [2:0] MODE_SPARE_C = 3'd7;

	typedef logic [63:0] word_t;

	// one parsed number as it leaves the block
	typedef struct packed {
		word_t value;
		logic  ovf;
	} number_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_ALTERNATE
	} stall_pattern_t;

	// clock, reset and block ports; the inputs are known from time zero
	logic           clk           = 1'b0;
	logic           arst_n        = 1'b0;
	logic           in_valid      = 1'b0;
	logic           in_stall;
	logic [7:0]     in_byte       = '0;
	logic           out_valid;
	logic           out_stall     = 1'b0;
	logic [OUT_BITS-1:0] number_value;
	logic           overflow_flag;
	logic           cfg_we        = 1'b0;
	reg_index_t     cfg_index     = REG_PARSE_MODE;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// characters waiting to be offered, numbers waiting to come out
	logic [7:0]     text_bytes [$];
	number_t        numbers_due [$];
	int unsigned    mismatches    = 0;

	// register copies used by the parser model
	logic [2:0]     cur_mode      = MODE_RESET;
	logic [4:0]     cur_frac      = '0;

	// token state of the parser model
	phase_t         tok_phase     = PH_SKIP;
	logic           tok_neg       = 1'b0;
	word_t          tok_acc       = '0;
	logic [4:0]     tok_frac_cnt  = '0;
	logic           tok_ovf       = 1'b0;

	// sender burst shaping
	int unsigned    burst_left    = 0;
	int unsigned    gap_left      = 0;
	number_t        parsed;

	// receiver stall shaping
	stall_pattern_t pattern_kind  = STALL_NONE;
	int unsigned    pattern_left  = 0;
	int unsigned    hold_left     = 0;
	int unsigned    holds_done    = 0;

	int unsigned    quiet_cycles  = 0;
	number_t        due;

	// settings walked through after the directed part; a negative fraction means pick at random
	logic [2:0] phase_mode [NUM_PHASES] = '{MODE_UFIX, MODE_SFIX, MODE_UINT, MODE_DIGIT,
		MODE_SFIX, MODE_UFIX, MODE_SPARE_A, MODE_SPARE_B, MODE_SPARE_C, MODE_SINT,
		MODE_UFIX, MODE_SFIX, MODE_DIGIT, MODE_SFIX};
	int phase_frac [NUM_PHASES] = '{0, 18, -1, -1, 0, 18, -1, -1, -1, -1, -1, -1, -1, -1};

	// magnitudes around the 64-bit and signed limits
	string big_numbers [5] = '{"18446744073709551615", "18446744073709551616",
		"9223372036854775807", "9223372036854775808", "99999999999999999999"};

	ascii_decimal_number_parser_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.number_value  (number_value),
		.overflow_flag (overflow_flag),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// first ten failures in full, the rest only counted
	function void note_error(string msg);
		if (mismatches < 10)
			$display("%s", msg);
		mismatches++;
	endfunction

	// clears the partial token and the negative mark
	function void clear_token();
		tok_phase    = PH_SKIP;
		tok_neg      = 1'b0;
		tok_acc      = '0;
		tok_frac_cnt = '0;
		tok_ovf      = 1'b0;
	endfunction

	// parser model: takes one character under the current registers and
	// returns 1 when the character completes a number
	function automatic bit parse_char(input logic [7:0] ch, output number_t res);
		logic        is_digit;
		logic        sgn;
		logic        fix;
		word_t       d;
		int unsigned c;
		is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
		d   = is_digit ? word_t'(ch - CHAR_ZERO) : '0;
		sgn = (cur_mode == MODE_SINT) || (cur_mode == MODE_SFIX);
		fix = (cur_mode == MODE_UFIX) || (cur_mode == MODE_SFIX);
		res = '0;
		// single digit mode: every character drops any token, digits leave at once
		if (cur_mode == MODE_DIGIT) begin
			clear_token();
			res.value = d;
			return is_digit;
		end
		if (tok_phase == PH_INT || tok_phase == PH_FRAC) begin
			if (is_digit) begin
				// wrap modulo 2^64 and remember that it happened
				if (tok_acc > ('1 - d) / 64'd10)
					tok_ovf = 1'b1;
				tok_acc = tok_acc * 64'd10 + d;
				if (tok_phase == PH_FRAC && tok_frac_cnt != FRAC_COUNT_MAX)
					tok_frac_cnt++;
				return 0;
			end
			if (tok_phase == PH_INT && ch == CHAR_DOT && fix) begin
				tok_phase = PH_FRAC;
				return 0;
			end
			// ending character: scale up missing fraction places, surplus ones stay
			if (fix) begin
				for (c = tok_frac_cnt; c < cur_frac; c++) begin
					if (tok_acc > word_t'('1) / 64'd10)
						tok_ovf = 1'b1;
					tok_acc = tok_acc * 64'd10;
				end
			end
			res.value = (sgn && tok_neg) ? word_t'(64'd0 - tok_acc) : tok_acc;
			res.ovf   = tok_ovf;
			clear_token();
			return 1;
		end
		// skipping: a digit opens a token, a minus marks it in the signed modes
		if (is_digit) begin
			tok_phase    = PH_INT;
			tok_acc      = d;
			tok_frac_cnt = '0;
			tok_ovf      = 1'b0;
		end else if (ch == CHAR_MINUS && sgn) begin
			tok_neg = 1'b1;
		end
		return 0;
	endfunction

	// any non-digit, favouring the characters the parser treats specially
	function automatic logic [7:0] pick_separator();
		logic [7:0] b;
		case ($urandom_range(0, 5))
			0: b = " ";
			1: b = CHAR_MINUS;
			2: b = CHAR_DOT;
			3: b = ",";
			4: b = "\n";
			default: begin
				b = 8'($urandom_range(0, 245));
				if (b >= CHAR_ZERO)
					b = b + 8'd10;
			end
		endcase
		return b;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			text_bytes.push_back(s[i]);
	endfunction

	function automatic void push_digits(int unsigned n);
		repeat (n) text_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	// one well-formed token: separators and maybe a minus, integer digits,
	// maybe a dot with fraction digits, then an ending character
	function automatic void add_token();
		int unsigned n;
		int unsigned k;
		repeat ($urandom_range(0, 2)) text_bytes.push_back(pick_separator());
		if ($urandom_range(0, 2) == 0)
			text_bytes.push_back(CHAR_MINUS);
		k = $urandom_range(0, 19);
		if (k == 0)
			push_text(big_numbers[$urandom_range(0, 4)]);
		else
			push_digits((k < 3) ? $urandom_range(15, 24) : $urandom_range(1, 6));
		if ($urandom_range(0, 2) == 0) begin
			text_bytes.push_back(CHAR_DOT);
			// mostly short fractions, a few past the fraction count ceiling
			k = $urandom_range(0, 19);
			n = (k == 0) ? $urandom_range(28, 36) : (k < 5) ? $urandom_range(5, 20)
				: $urandom_range(0, 4);
			push_digits(n);
		end
		text_bytes.push_back(pick_separator());
	endfunction

	// writes both registers back to back; only called while the block is idle
	task automatic configure(input logic [2:0] mode, input logic [4:0] frac);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PARSE_MODE;
		cfg_data  <= CFG_DATA_BITS'(mode);
		@(posedge clk);
		cfg_index <= REG_FRAC_DIGITS;
		cfg_data  <= frac;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_mode   = mode;
		cur_frac   = frac;
	endtask

	// waits until every character is taken and every number is back, then lets the pipe settle
	task automatic drain();
		while (text_bytes.size() != 0 || in_valid || numbers_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	// character driver: predicts on every taken request, then offers the next
	// character in bursts; a stalled request holds its payload
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				if (parse_char(in_byte, parsed))
					numbers_due.push_back(parsed);
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (text_bytes.size() != 0) begin
					in_valid <= 1'b1;
					in_byte  <= text_bytes.pop_front();
					if (burst_left > 1)
						burst_left--;
					else begin
						// new burst; often no gap at all so back-to-back runs occur
						burst_left = $urandom_range(1, 48);
						gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: switches between stall patterns, and once the sender has a
	// full phase queued holds off long enough for the block to back up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if ((holds_done == 0 && text_bytes.size() > 100)
				|| (holds_done != 0 && $urandom_range(0, 2999) == 0)) begin
			holds_done++;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			if (pattern_left == 0) begin
				pattern_kind = stall_pattern_t'($urandom_range(0, 3));
				pattern_left = $urandom_range(16, 160);
			end else begin
				pattern_left--;
			end
			case (pattern_kind)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
				default:     out_stall <= ~out_stall;
			endcase
		end
	end

	// number monitor: each taken request against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (numbers_due.size() == 0) begin
				note_error($sformatf("unexpected number %0d flag %0b",
					$signed(number_value), overflow_flag));
			end else begin
				due = numbers_due.pop_front();
				if (number_value !== due.value || overflow_flag !== due.ovf)
					note_error($sformatf("number mismatch: expected %0d flag %0b, got %0d flag %0b",
						$signed(due.value), due.ovf, $signed(number_value), overflow_flag));
			end
		end
	end

	// watchdog on stretches with no request taken on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("no progress for %0d cycles", WATCHDOG_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset settings (signed integer, no fraction places):
		// byte extremes, a minus kept across skipped characters, a minus that ends a
		// token and so does not mark the next one, a dot that ends a token outside
		// the fixed modes, the characters either side of the digit range, and a
		// token left open across the first change of mode
		text_bytes.push_back(8'h00);
		push_text("-9");
		text_bytes.push_back(8'hFF);
		push_text("12-3 -x5./0:");
		text_bytes.push_back(8'h80);
		text_bytes.push_back(8'h7F);
		push_text("7");
		drain();

		// random part: each setting gets mostly well-formed tokens with some raw noise
		for (int p = 0; p < NUM_PHASES; p++) begin
			configure(phase_mode[p],
				(phase_frac[p] < 0) ? 5'($urandom_range(0, FRAC_TOP)) : 5'(phase_frac[p]));
			while (text_bytes.size() < PHASE_ITEMS) begin
				if ($urandom_range(0, 6) == 0)
					repeat ($urandom_range(1, 6)) text_bytes.push_back(8'($urandom_range(0, 255)));
				else
					add_token();
			end
			drain();
		end

		if (numbers_due.size() != 0)
			note_error($sformatf("%0d numbers never arrived", numbers_due.size()));
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/adnp_pkg.sv
hw/rtl/adnp_scan.sv
hw/rtl/adnp_scaler.sv
hw/rtl/ascii_decimal_number_parser_core.sv
tb/sv/ascii_decimal_number_parser_core_test.sv
